// ----- rtl/gravity_acceleration_vector_unit_assert.svh -----
// Assertion macros shared by the gravity acceleration unit.
`ifndef GRAVITY_ACCELERATION_VECTOR_UNIT_ASSERT_SVH
`define GRAVITY_ACCELERATION_VECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define GAV_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define GAV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/gav_pkg.sv -----
// Shared types and constants for the gravity acceleration unit.
`timescale 1ns / 1ps
package gav_pkg;

    // Field and intermediate widths
    localparam int POS_W    = 48;   // position and delta magnitude
    localparam int MASS_W   = 32;
    localparam int GRAV_W   = 40;
    localparam int ACC_W    = 64;
    localparam int DIST_W   = 49;   // floor of separation
    localparam int DIST2_W  = 97;   // squared separation
    localparam int DIST4_W  = 194;
    localparam int DIST6_W  = 291;  // cube of squared separation
    localparam int GM_W     = 72;
    localparam int PROD_W   = 120;  // GM times delta magnitude
    localparam int PSQ_W    = 240;
    localparam int NUM2_W   = 304;  // squared numerator with the 2^32 scale

    // Configuration register map
    localparam int           APB_ADDR_W   = 3;
    localparam int           APB_DATA_W   = 64;
    localparam logic [APB_ADDR_W-1:0] ADDR_GRAVITY = 3'd0;
    localparam logic [GRAV_W-1:0]     GRAVITY_RESET = 40'd66740000000;

    // Saturation limits of one acceleration component
    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // One classified transaction from the front end
    typedef struct packed {
        logic [POS_W-1:0]  mag_x;
        logic [POS_W-1:0]  mag_y;
        logic              neg_x;
        logic              neg_y;
        logic              coin;
        logic [MASS_W-1:0] mass;
    } t_item;

    // One finished result
    typedef struct packed {
        logic [ACC_W-1:0]  accel_x;
        logic [ACC_W-1:0]  accel_y;
        logic [DIST_W-1:0] separation;
        logic              coincident;
        logic              saturated;
    } t_result;

endpackage

// ----- rtl/gav_fifo.sv -----
// Small register queue with a combinational head.
`timescale 1ns / 1ps
module gav_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- rtl/gav_mul.sv -----
// Pipelined wide multiplier: one 32x32 partial product per stage.
`timescale 1ns / 1ps
module gav_mul #(
    parameter int WA = 32,
    parameter int WB = 32,
    parameter int WP = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [WA-1:0]    i_a,
    input  logic [WB-1:0]    i_b,
    input  logic [WP-1:0]    i_pay,
    output logic             o_valid,
    output logic [WA+WB-1:0] o_p,
    output logic [WP-1:0]    o_pay
);
    localparam int CA  = (WA + 31) / 32;
    localparam int CB  = (WB + 31) / 32;
    localparam int NS  = CA * CB;
    localparam int WAP = 32 * CA;
    localparam int WBP = 32 * CB;
    localparam int WPR = WA + WB;

    logic           r_valid [NS];
    logic [WPR-1:0] r_acc   [NS];
    logic [WAP-1:0] r_a     [NS];
    logic [WBP-1:0] r_b     [NS];
    logic [WP-1:0]  r_pay   [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam int II = k / CB;
        localparam int JJ = k % CB;
        logic           s_valid;
        logic [WPR-1:0] s_acc;
        logic [WAP-1:0] s_a;
        logic [WBP-1:0] s_b;
        logic [WP-1:0]  s_pay;
        logic [63:0]    pp;
        logic [WPR+63:0] pp_wide;

        if (k == 0) begin : g_first
            assign s_valid = i_valid;
            assign s_acc   = '0;
            assign s_a     = WAP'(i_a);
            assign s_b     = WBP'(i_b);
            assign s_pay   = i_pay;
        end else begin : g_next
            assign s_valid = r_valid[k-1];
            assign s_acc   = r_acc[k-1];
            assign s_a     = r_a[k-1];
            assign s_b     = r_b[k-1];
            assign s_pay   = r_pay[k-1];
        end

        // one partial product, aligned and accumulated
        assign pp      = 64'(s_a[32*II +: 32]) * 64'(s_b[32*JJ +: 32]);
        assign pp_wide = {{WPR{1'b0}}, pp} << (32 * (II + JJ));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= s_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[k] <= s_acc + pp_wide[WPR-1:0];
                r_a[k]   <= s_a;
                r_b[k]   <= s_b;
                r_pay[k] <= s_pay;
            end
        end
    end

    assign o_valid = r_valid[NS-1];
    assign o_p     = r_acc[NS-1];
    assign o_pay   = r_pay[NS-1];

endmodule

// ----- rtl/gav_root.sv -----
// Pipelined root search: largest q with q*q*K <= V, one result bit per stage.
`timescale 1ns / 1ps
module gav_root #(
    parameter int WR = 8,
    parameter int WV = 16,
    parameter int WK = 1,
    parameter int WP = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [WV-1:0] i_v,
    input  logic [WK-1:0] i_k,
    input  logic [WP-1:0] i_pay,
    output logic          o_valid,
    output logic [WR-1:0] o_q,
    output logic [WP-1:0] o_pay
);
    localparam int WS = (WV > WK + 2 * WR) ? WV : WK + 2 * WR;
    localparam int WT = WS + 2;
    localparam int WB = WK + WR;

    // per stage: q*q*K, q*K, q, and the operands carried along
    logic          r_valid [WR];
    logic [WT-1:0] r_sq    [WR];
    logic [WB-1:0] r_lin   [WR];
    logic [WR-1:0] r_q     [WR];
    logic [WV-1:0] r_v     [WR];
    logic [WK-1:0] r_k     [WR];
    logic [WP-1:0] r_pay   [WR];

    for (genvar t = 0; t < WR; t++) begin : g_step
        localparam int BIT = WR - 1 - t;
        logic          s_valid;
        logic [WT-1:0] s_sq;
        logic [WB-1:0] s_lin;
        logic [WR-1:0] s_q;
        logic [WV-1:0] s_v;
        logic [WK-1:0] s_k;
        logic [WP-1:0] s_pay;
        logic [WT-1:0] cand;
        logic          take;

        if (t == 0) begin : g_first
            assign s_valid = i_valid;
            assign s_sq    = '0;
            assign s_lin   = '0;
            assign s_q     = '0;
            assign s_v     = i_v;
            assign s_k     = i_k;
            assign s_pay   = i_pay;
        end else begin : g_next
            assign s_valid = r_valid[t-1];
            assign s_sq    = r_sq[t-1];
            assign s_lin   = r_lin[t-1];
            assign s_q     = r_q[t-1];
            assign s_v     = r_v[t-1];
            assign s_k     = r_k[t-1];
            assign s_pay   = r_pay[t-1];
        end

        // (q + 2^b)^2 K = q^2 K + 2^(b+1) qK + 2^(2b) K
        assign cand = s_sq + (WT'(s_lin) << (BIT + 1)) + (WT'(s_k) << (2 * BIT));
        assign take = (cand <= WT'(s_v));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[t] <= 1'b0;
            end else if (i_en) begin
                r_valid[t] <= s_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq[t]  <= take ? cand : s_sq;
                r_lin[t] <= take ? s_lin + (WB'(s_k) << BIT) : s_lin;
                r_q[t]   <= take ? (s_q | (WR'(1) << BIT)) : s_q;
                r_v[t]   <= s_v;
                r_k[t]   <= s_k;
                r_pay[t] <= s_pay;
            end
        end
    end

    assign o_valid = r_valid[WR-1];
    assign o_q     = r_q[WR-1];
    assign o_pay   = r_pay[WR-1];

endmodule

// ----- rtl/gav_front.sv -----
// Front end: position deltas, magnitudes, signs and the coincidence check.
`timescale 1ns / 1ps
module gav_front import gav_pkg::*; (
    input  logic signed [POS_W-1:0] i_center_x,
    input  logic signed [POS_W-1:0] i_center_y,
    input  logic signed [POS_W-1:0] i_body_x,
    input  logic signed [POS_W-1:0] i_body_y,
    input  logic [MASS_W-1:0]       i_central_mass,
    output t_item                   o_item
);
    logic [POS_W:0] dx;
    logic [POS_W:0] dy;
    logic [POS_W:0] abs_x;
    logic [POS_W:0] abs_y;

    // sign-extended differences, body minus centre
    assign dx    = {i_body_x[POS_W-1], i_body_x} - {i_center_x[POS_W-1], i_center_x};
    assign dy    = {i_body_y[POS_W-1], i_body_y} - {i_center_y[POS_W-1], i_center_y};
    assign abs_x = dx[POS_W] ? (~dx + 1'b1) : dx;
    assign abs_y = dy[POS_W] ? (~dy + 1'b1) : dy;

    // magnitudes fit 48 bits, the difference range being symmetric
    always_comb begin
        o_item.mag_x = abs_x[POS_W-1:0];
        o_item.mag_y = abs_y[POS_W-1:0];
        o_item.neg_x = dx[POS_W];
        o_item.neg_y = dy[POS_W];
        o_item.coin  = (dx == '0) && (dy == '0);
        o_item.mass  = i_central_mass;
    end

endmodule

// ----- rtl/gav_back.sv -----
// Back end: arithmetic pipeline from deltas to separation and acceleration.
`timescale 1ns / 1ps
module gav_back import gav_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [GRAV_W-1:0] i_gravity,
    input  logic              i_avail,
    input  t_item             i_item,
    output logic              o_take,
    output logic              o_push,
    output t_result           o_res,
    input  logic              i_full
);
    typedef struct packed {
        logic [DIST2_W-1:0] d;
        t_item              item;
    } t_p1;

    typedef struct packed {
        logic [DIST2_W-1:0] d;
        logic [DIST_W-1:0]  sep;
        t_item              item;
    } t_p2;

    typedef struct packed {
        logic [DIST_W-1:0]  sep;
        t_item              item;
    } t_p3;

    typedef struct packed {
        logic [DIST6_W-1:0] d3;
        logic [DIST_W-1:0]  sep;
        t_item              item;
    } t_p4;

    // sign and clamp: bit ACC_W is the saturation flag
    function automatic logic [ACC_W:0] signed_accel(input logic [ACC_W-1:0] q,
                                                    input logic neg);
        logic [ACC_W:0] res;
        if (neg) begin
            res = (q > ACC_MAX) ? {1'b1, ACC_MAX} : {1'b0, q};
        end else begin
            res = (q > ACC_MIN) ? {1'b1, ACC_MIN} : {1'b0, ~q + 1'b1};
        end
        return res;
    endfunction

    logic en;
    logic root_valid;

    // whole pipeline holds while a finished result cannot be queued
    assign en     = !root_valid || !i_full;
    assign o_take = en && i_avail;

    // squares of the deltas
    logic                   sq_valid;
    logic [2*POS_W-1:0]     sq_x;
    logic [2*POS_W-1:0]     sq_y;
    t_item                  sq_item;

    gav_mul #(.WA(POS_W), .WB(POS_W), .WP($bits(t_item))) u_sq_x (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(i_avail),
        .i_a(i_item.mag_x), .i_b(i_item.mag_x), .i_pay(i_item),
        .o_valid(sq_valid), .o_p(sq_x), .o_pay(sq_item)
    );
    gav_mul #(.WA(POS_W), .WB(POS_W), .WP(1)) u_sq_y (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(i_avail),
        .i_a(i_item.mag_y), .i_b(i_item.mag_y), .i_pay(1'b0),
        .o_valid(), .o_p(sq_y), .o_pay()
    );

    // squared separation
    logic               r_d_valid;
    logic [DIST2_W-1:0] r_d;
    t_item              r_d_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (en) begin
            r_d_valid <= sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d      <= {1'b0, sq_x} + {1'b0, sq_y};
            r_d_item <= sq_item;
        end
    end

    // separation, floor of the square root
    t_p1               p1_in;
    t_p1               p1_out;
    logic              sep_valid;
    logic [DIST_W-1:0] sep;

    always_comb begin
        p1_in.d    = r_d;
        p1_in.item = r_d_item;
    end

    gav_root #(.WR(DIST_W), .WV(DIST2_W), .WK(1), .WP($bits(t_p1))) u_sqrt (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_d_valid),
        .i_v(r_d), .i_k(1'b1), .i_pay(p1_in),
        .o_valid(sep_valid), .o_q(sep), .o_pay(p1_out)
    );

    // fourth power of the separation
    t_p2                p2_in;
    t_p2                p2_out;
    logic               d2_valid;
    logic [DIST4_W-1:0] d2;

    always_comb begin
        p2_in.d    = p1_out.d;
        p2_in.sep  = sep;
        p2_in.item = p1_out.item;
    end

    gav_mul #(.WA(DIST2_W), .WB(DIST2_W), .WP($bits(t_p2))) u_d2 (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(sep_valid),
        .i_a(p1_out.d), .i_b(p1_out.d), .i_pay(p2_in),
        .o_valid(d2_valid), .o_p(d2), .o_pay(p2_out)
    );

    // sixth power of the separation
    t_p3                p3_in;
    t_p3                p3_out;
    logic               d3_valid;
    logic [DIST6_W-1:0] d3;

    always_comb begin
        p3_in.sep  = p2_out.sep;
        p3_in.item = p2_out.item;
    end

    gav_mul #(.WA(DIST4_W), .WB(DIST2_W), .WP($bits(t_p3))) u_d3 (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(d2_valid),
        .i_a(d2), .i_b(p2_out.d), .i_pay(p3_in),
        .o_valid(d3_valid), .o_p(d3), .o_pay(p3_out)
    );

    // GM
    t_p4             p4_in;
    t_p4             p4_gm;
    logic            gm_valid;
    logic [GM_W-1:0] gm;

    always_comb begin
        p4_in.d3   = d3;
        p4_in.sep  = p3_out.sep;
        p4_in.item = p3_out.item;
    end

    gav_mul #(.WA(GRAV_W), .WB(MASS_W), .WP($bits(t_p4))) u_gm (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(d3_valid),
        .i_a(i_gravity), .i_b(p3_out.item.mass), .i_pay(p4_in),
        .o_valid(gm_valid), .o_p(gm), .o_pay(p4_gm)
    );

    // GM times each delta magnitude
    t_p4               p4_prod;
    logic              prod_valid;
    logic [PROD_W-1:0] prod_x;
    logic [PROD_W-1:0] prod_y;

    gav_mul #(.WA(GM_W), .WB(POS_W), .WP($bits(t_p4))) u_prod_x (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(gm_valid),
        .i_a(gm), .i_b(p4_gm.item.mag_x), .i_pay(p4_gm),
        .o_valid(prod_valid), .o_p(prod_x), .o_pay(p4_prod)
    );
    gav_mul #(.WA(GM_W), .WB(POS_W), .WP(1)) u_prod_y (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(gm_valid),
        .i_a(gm), .i_b(p4_gm.item.mag_y), .i_pay(1'b0),
        .o_valid(), .o_p(prod_y), .o_pay()
    );

    // squared numerators
    t_p4              p4_psq;
    logic             psq_valid;
    logic [PSQ_W-1:0] psq_x;
    logic [PSQ_W-1:0] psq_y;

    gav_mul #(.WA(PROD_W), .WB(PROD_W), .WP($bits(t_p4))) u_psq_x (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(prod_valid),
        .i_a(prod_x), .i_b(prod_x), .i_pay(p4_prod),
        .o_valid(psq_valid), .o_p(psq_x), .o_pay(p4_psq)
    );
    gav_mul #(.WA(PROD_W), .WB(PROD_W), .WP(1)) u_psq_y (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(prod_valid),
        .i_a(prod_y), .i_b(prod_y), .i_pay(1'b0),
        .o_valid(), .o_p(psq_y), .o_pay()
    );

    // quotient roots: largest q with q^2 d^6 <= (GM |delta| 2^32)^2
    t_p3              p5_in;
    t_p3              p5_out;
    logic [ACC_W-1:0] q_x;
    logic [ACC_W-1:0] q_y;

    always_comb begin
        p5_in.sep  = p4_psq.sep;
        p5_in.item = p4_psq.item;
    end

    gav_root #(.WR(ACC_W), .WV(NUM2_W), .WK(DIST6_W), .WP($bits(t_p3))) u_root_x (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(psq_valid),
        .i_v({psq_x, {ACC_W{1'b0}}}), .i_k(p4_psq.d3), .i_pay(p5_in),
        .o_valid(root_valid), .o_q(q_x), .o_pay(p5_out)
    );
    gav_root #(.WR(ACC_W), .WV(NUM2_W), .WK(DIST6_W), .WP(1)) u_root_y (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(psq_valid),
        .i_v({psq_y, {ACC_W{1'b0}}}), .i_k(p4_psq.d3), .i_pay(1'b0),
        .o_valid(), .o_q(q_y), .o_pay()
    );

    // sign, clamp and the coincident override
    logic [ACC_W:0] fin_x;
    logic [ACC_W:0] fin_y;

    assign fin_x  = signed_accel(q_x, p5_out.item.neg_x);
    assign fin_y  = signed_accel(q_y, p5_out.item.neg_y);
    assign o_push = root_valid && en;

    always_comb begin
        if (p5_out.item.coin) begin
            o_res.accel_x    = '0;
            o_res.accel_y    = '0;
            o_res.separation = '0;
            o_res.coincident = 1'b1;
            o_res.saturated  = 1'b0;
        end else begin
            o_res.accel_x    = fin_x[ACC_W-1:0];
            o_res.accel_y    = fin_y[ACC_W-1:0];
            o_res.separation = p5_out.sep;
            o_res.coincident = 1'b0;
            o_res.saturated  = fin_x[ACC_W] || fin_y[ACC_W];
        end
    end

endmodule

// ----- rtl/gravity_acceleration_vector_unit.sv -----
// Top level of the 2-D point-mass gravitational acceleration unit.
`timescale 1ns / 1ps
// Takes one body pair per clock unless stalled and returns, in order, the floor of
// the separation and the Q31.32 acceleration -GM*delta/d^3 on the orbiting body,
// truncated toward zero and clamped to 64 bits. Throughput is one transaction per
// cycle while the output side does not stall. Delay to the output queue head is set
// mostly by the two bit-per-stage root units (49 stages for the separation, 64 for
// the quotient) and the chains of 32x32 partial-product stages that build d^6 and
// the squared numerators. When the output side stalls, the whole arithmetic pipeline
// holds and the input queue fills before full is raised. The gravity register (GM
// per mass unit) sits at byte address 0 of the configuration port.
`include "gravity_acceleration_vector_unit_assert.svh"
module gravity_acceleration_vector_unit import gav_pkg::*; #(
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input queue side
    input  logic                    push,
    output logic                    full,
    input  logic signed [POS_W-1:0] i_center_x,
    input  logic signed [POS_W-1:0] i_center_y,
    input  logic signed [POS_W-1:0] i_body_x,
    input  logic signed [POS_W-1:0] i_body_y,
    input  logic [MASS_W-1:0]       i_central_mass,
    // result queue side
    output logic                    empty,
    input  logic                    pop,
    output logic signed [ACC_W-1:0] o_accel_x,
    output logic signed [ACC_W-1:0] o_accel_y,
    output logic [DIST_W-1:0]       o_separation,
    output logic                    o_coincident,
    output logic                    o_saturated,
    // configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);
    logic [GRAV_W-1:0] r_gravity;
    logic              cfg_wr;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_GRAVITY);
    assign prdata = (paddr == ADDR_GRAVITY) ? APB_DATA_W'(r_gravity) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= GRAVITY_RESET;
        end else if (cfg_wr) begin
            r_gravity <= pwdata[GRAV_W-1:0];
        end
    end

    // front end and the queue to the back end
    t_item   fr_item;
    t_item   mid_item;
    logic    mid_empty;
    logic    mid_pop;

    gav_front u_front (
        .i_center_x, .i_center_y, .i_body_x, .i_body_y, .i_central_mass,
        .o_item(fr_item)
    );

    gav_fifo #(.W($bits(t_item)), .DEPTH(MID_DEPTH)) u_mid_q (
        .i_clk, .i_rst_n,
        .i_push(push), .i_data(fr_item), .o_full(full),
        .i_pop(mid_pop), .o_data(mid_item), .o_empty(mid_empty)
    );

    // back end and the result queue
    t_result res;
    t_result out_res;
    logic    res_push;
    logic    res_full;

    gav_back u_back (
        .i_clk, .i_rst_n, .i_gravity(r_gravity),
        .i_avail(!mid_empty), .i_item(mid_item), .o_take(mid_pop),
        .o_push(res_push), .o_res(res), .i_full(res_full)
    );

    gav_fifo #(.W($bits(t_result)), .DEPTH(OUT_DEPTH)) u_out_q (
        .i_clk, .i_rst_n,
        .i_push(res_push), .i_data(res), .o_full(res_full),
        .i_pop(pop), .o_data(out_res), .o_empty(empty)
    );

    assign o_accel_x    = out_res.accel_x;
    assign o_accel_y    = out_res.accel_y;
    assign o_separation = out_res.separation;
    assign o_coincident = out_res.coincident;
    assign o_saturated  = out_res.saturated;

    // terms used by the checks
    logic in_acc;
    logic head_coin;
    logic head_dist;
    logic head_zero;

    assign in_acc    = push && !full;
    assign head_coin = !empty && o_coincident;
    assign head_dist = !empty && !o_coincident;
    assign head_zero = (o_accel_x == '0) && (o_accel_y == '0) && (o_separation == '0)
                       && !o_saturated;

    // checks
    `GAV_ASSERT_IMPLIES(a_no_push_when_full, res_push, !res_full, "result pushed into full queue")
    `GAV_ASSERT_IMPLIES(a_coin_zero, head_coin, head_zero, "coincident result not zero")
    `GAV_ASSERT_IMPLIES(a_sep_nonzero, head_dist, o_separation != '0, "zero separation")
    `GAV_ASSERT_NEXT(a_no_bypass, in_acc && empty && !res_push, empty, "result without latency")

endmodule
